[sv/gmds_pkg.sv]
// Shared constants and types of the grid maze depth-first solver.
package gmds_pkg;

   // Default store size
   localparam int MAX_ROWS_DEF = 32;
   localparam int MAX_COLS_DEF = 32;

   // Field widths
   localparam int COORD_W   = 5;
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 11;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   // Cell characters
   localparam logic [BYTE_W-1:0] CH_WALL  = 8'h7C;
   localparam logic [BYTE_W-1:0] CH_START = 8'h53;
   localparam logic [BYTE_W-1:0] CH_END   = 8'h45;
   localparam logic [BYTE_W-1:0] CH_MARK  = 8'h78;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd1;

   // Reset values of the registers
   localparam logic [CFG_W-1:0] GRID_ROWS_RST = 6'd32;
   localparam logic [CFG_W-1:0] GRID_COLS_RST = 6'd32;

   // Item kinds
   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_SOLVE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   // Walk directions, in the order they are tried; DIR_DONE means all tried
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;
   localparam logic [2:0] DIR_DONE  = 3'd4;

   // Per-cell walk record: visited mark, arrival direction, next direction
   typedef struct packed {
      logic       visited;
      logic [1:0] from;
      logic [2:0] next_dir;
   } meta_type;

endpackage

[sv/grid_maze_dfs_solver.sv]
// Top level of the grid maze depth-first solver: grid store, walk record store, sequencer.
//
// Usage: items arrive on the req_ stream, req_tuser carries the kind (load, solve,
// read) and req_tdata the cell coordinates and byte. Results leave on the rsp_ stream.
// A load gives no result. A read's byte passes through the registered read port of the
// grid store and then the output register. A solve first sweeps the used area, one
// cell a cycle, to find the start and clear the visited marks. The walk then tries an
// out-of-range direction within the step state, while every probed neighbor and every
// backtrack waits on one read of the single read port of the walk record store.
// Marking the path reads the arrival direction of each cell on it but the start.
// The DFS stack is the chain of arrival directions from the current cell back to
// the start, so it lives in the walk record store. New items are taken only
// between items, but a load may be taken while a result still waits in the output
// register; a read or solve that finishes then holds until the register is free.
// Reset clears the control state and sets both size registers to 32; the grid store
// is not cleared. csr_ accepts a write in every cycle and should be used only while
// the block is idle.
module grid_maze_dfs_solver #(
   parameter int MAX_ROWS = gmds_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = gmds_pkg::MAX_COLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fields from bit 0: row[4:0], col[9:5], cell_byte[17:10], zero fill
   input  logic [gmds_pkg::REQ_DATA_W-1:0]   req_tdata,
   // fields from bit 0: mode[1:0]
   input  logic [gmds_pkg::REQ_USER_W-1:0]   req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fields from bit 0: found[0], path_length[11:1], cell_out[19:12], zero fill
   output logic [gmds_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gmds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gmds_pkg::CFG_W-1:0]        csr_data
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RUW   = $clog2(MAX_ROWS + 1);
   localparam int CUW   = $clog2(MAX_COLS + 1);
   localparam int XRW   = RW + gmds_pkg::COORD_W;
   localparam int XCW   = CW + gmds_pkg::COORD_W;
   localparam int BW    = gmds_pkg::BYTE_W;
   localparam int LW    = gmds_pkg::LEN_W;

   typedef struct packed {
      logic [RW-1:0] r;
      logic [CW-1:0] c;
   } coord_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_STEP,
      ST_PROBE,
      ST_POP_WAIT,
      ST_TRACE,
      ST_TRACE_WAIT,
      ST_DONE
   } state_type;

   // Linear store address of a cell
   function automatic logic [AW-1:0] addr_of(input coord_type p);
      addr_of = AW'(p.r) * AW'(MAX_COLS) + AW'(p.c);
   endfunction

   // Cell that a cell was entered from, given its arrival direction
   function automatic coord_type step_back(input coord_type p, input logic [1:0] from);
      coord_type q;
      q = p;
      unique case (from)
         gmds_pkg::DIR_UP:    q.r = p.r + RW'(1);
         gmds_pkg::DIR_DOWN:  q.r = p.r - RW'(1);
         gmds_pkg::DIR_LEFT:  q.c = p.c + CW'(1);
         gmds_pkg::DIR_RIGHT: q.c = p.c - CW'(1);
      endcase
      step_back = q;
   endfunction

   // Memories and their registered read data
   logic [BW-1:0]       grid_mem [CELLS];
   gmds_pkg::meta_type  meta_mem [CELLS];
   logic [BW-1:0]       grid_q_ff;
   gmds_pkg::meta_type  meta_q_ff;

   logic                grid_we, grid_re, meta_we, meta_re;
   logic [AW-1:0]       grid_waddr, grid_raddr, meta_waddr, meta_raddr;
   logic [BW-1:0]       grid_wdata;
   gmds_pkg::meta_type  meta_wdata;

   // Control and walk registers
   state_type           state_ff, state_in;
   logic [gmds_pkg::CFG_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [RUW-1:0]      used_rows_ff, used_rows_in;
   logic [CUW-1:0]      used_cols_ff, used_cols_in;
   coord_type           scan_ff, scan_in;
   logic                scan_pend_ff, scan_pend_in;
   coord_type           scan_prev_ff, scan_prev_in;
   logic                have_start_ff, have_start_in;
   coord_type           start_ff, start_in;
   coord_type           cur_ff, cur_in;
   logic [2:0]          cur_dir_ff, cur_dir_in;
   logic [1:0]          cur_from_ff, cur_from_in;
   coord_type           nb_ff, nb_in;
   logic [1:0]          probe_dir_ff, probe_dir_in;
   logic [LW-1:0]       count_ff, count_in;
   logic                found_ff, found_in;
   logic                read_inside_ff, read_inside_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [LW-1:0]       rsp_len_ff, rsp_len_in;
   logic [BW-1:0]       rsp_cell_ff, rsp_cell_in;

   // Request decode
   gmds_pkg::mode_type  req_mode;
   logic [XRW-1:0]      req_row_x;
   logic [XCW-1:0]      req_col_x;
   logic                req_inside;
   coord_type           req_cell;
   logic                req_fire, slot_free;

   assign req_mode   = gmds_pkg::mode_type'(req_tuser[1:0]);
   assign req_row_x  = XRW'(req_tdata[4:0]);
   assign req_col_x  = XCW'(req_tdata[9:5]);
   assign req_inside = (req_row_x < XRW'(MAX_ROWS)) && (req_col_x < XCW'(MAX_COLS));
   assign req_cell   = '{r: req_row_x[RW-1:0], c: req_col_x[CW-1:0]};
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Outputs
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(gmds_pkg::RSP_DATA_W - 1 - LW - BW)'(0), rsp_cell_ff, rsp_len_ff,
                        rsp_found_ff};

   // Sequencer
   always_comb begin
      coord_type  nb;
      logic       nb_ok;
      logic       scan_last_c, scan_last_r, hit;

      state_in       = state_ff;
      rows_in        = rows_ff;
      cols_in        = cols_ff;
      used_rows_in   = used_rows_ff;
      used_cols_in   = used_cols_ff;
      scan_in        = scan_ff;
      scan_pend_in   = scan_pend_ff;
      scan_prev_in   = scan_prev_ff;
      have_start_in  = have_start_ff;
      start_in       = start_ff;
      cur_in         = cur_ff;
      cur_dir_in     = cur_dir_ff;
      cur_from_in    = cur_from_ff;
      nb_in          = nb_ff;
      probe_dir_in   = probe_dir_ff;
      count_in       = count_ff;
      found_in       = found_ff;
      read_inside_in = read_inside_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_found_in   = rsp_found_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_cell_in    = rsp_cell_ff;

      grid_we    = 1'b0;
      grid_waddr = addr_of(cur_ff);
      grid_wdata = gmds_pkg::CH_MARK;
      grid_re    = 1'b0;
      grid_raddr = addr_of(scan_ff);
      meta_we    = 1'b0;
      meta_waddr = addr_of(cur_ff);
      meta_wdata = '0;
      meta_re    = 1'b0;
      meta_raddr = addr_of(cur_ff);

      nb          = cur_ff;
      nb_ok       = 1'b0;
      scan_last_c = (CUW'(scan_ff.c) + CUW'(1)) == used_cols_ff;
      scan_last_r = (RUW'(scan_ff.r) + RUW'(1)) == used_rows_ff;
      hit         = scan_pend_ff && (grid_q_ff == gmds_pkg::CH_START);

      // Register writes
      if (csr_valid) begin
         if (csr_index == gmds_pkg::CSR_GRID_ROWS) begin
            rows_in = csr_data;
         end else if (csr_index == gmds_pkg::CSR_GRID_COLS) begin
            cols_in = csr_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  gmds_pkg::MODE_LOAD: begin
                     grid_we    = req_inside;
                     grid_waddr = addr_of(req_cell);
                     grid_wdata = req_tdata[17:10];
                  end
                  gmds_pkg::MODE_READ: begin
                     grid_re        = req_inside;
                     grid_raddr     = addr_of(req_cell);
                     read_inside_in = req_inside;
                     state_in       = ST_READ_WAIT;
                  end
                  gmds_pkg::MODE_SOLVE: begin
                     // clamp the used area
                     if (rows_ff == '0) begin
                        used_rows_in = RUW'(1);
                     end else if (rows_ff > MAX_ROWS) begin
                        used_rows_in = RUW'(MAX_ROWS);
                     end else begin
                        used_rows_in = RUW'(rows_ff);
                     end
                     if (cols_ff == '0) begin
                        used_cols_in = CUW'(1);
                     end else if (cols_ff > MAX_COLS) begin
                        used_cols_in = CUW'(MAX_COLS);
                     end else begin
                        used_cols_in = CUW'(cols_ff);
                     end
                     scan_in       = '0;
                     scan_pend_in  = 1'b0;
                     have_start_in = 1'b0;
                     count_in      = '0;
                     found_in      = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ_WAIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_len_in   = '0;
               rsp_cell_in  = read_inside_ff ? grid_q_ff : '0;
               state_in     = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // read one cell, clear its walk record, check the cell read before
            grid_re      = 1'b1;
            grid_raddr   = addr_of(scan_ff);
            meta_we      = 1'b1;
            meta_waddr   = addr_of(scan_ff);
            meta_wdata   = '0;
            scan_pend_in = 1'b1;
            scan_prev_in = scan_ff;
            if (hit) begin
               have_start_in = 1'b1;
               start_in      = scan_prev_ff;
            end
            if (scan_last_c) begin
               scan_in.c = '0;
               scan_in.r = scan_ff.r + RW'(1);
               if (scan_last_r) begin
                  state_in = ST_SCAN_TAIL;
               end
            end else begin
               scan_in.c = scan_ff.c + CW'(1);
            end
         end

         ST_SCAN_TAIL: begin
            if (hit) begin
               have_start_in = 1'b1;
               start_in      = scan_prev_ff;
            end
            if (hit || have_start_ff) begin
               cur_in      = start_in;
               cur_dir_in  = '0;
               cur_from_in = gmds_pkg::DIR_UP;
               state_in    = ST_STEP;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_STEP: begin
            if (cur_dir_ff == gmds_pkg::DIR_DONE) begin
               // all directions tried: drop back to the entering cell
               if (cur_ff == start_ff) begin
                  state_in = ST_DONE;
               end else begin
                  cur_in     = step_back(cur_ff, cur_from_ff);
                  meta_re    = 1'b1;
                  meta_raddr = addr_of(cur_in);
                  state_in   = ST_POP_WAIT;
               end
            end else begin
               unique case (cur_dir_ff[1:0])
                  gmds_pkg::DIR_UP: begin
                     nb_ok = cur_ff.r != '0;
                     nb.r  = cur_ff.r - RW'(1);
                  end
                  gmds_pkg::DIR_DOWN: begin
                     nb_ok = (RUW'(cur_ff.r) + RUW'(1)) < used_rows_ff;
                     nb.r  = cur_ff.r + RW'(1);
                  end
                  gmds_pkg::DIR_LEFT: begin
                     nb_ok = cur_ff.c != '0;
                     nb.c  = cur_ff.c - CW'(1);
                  end
                  gmds_pkg::DIR_RIGHT: begin
                     nb_ok = (CUW'(cur_ff.c) + CUW'(1)) < used_cols_ff;
                     nb.c  = cur_ff.c + CW'(1);
                  end
               endcase
               cur_dir_in = cur_dir_ff + 3'd1;
               if (nb_ok) begin
                  // save progress of this cell, probe the neighbor
                  meta_we      = 1'b1;
                  meta_waddr   = addr_of(cur_ff);
                  meta_wdata   = '{visited: 1'b1, from: cur_from_ff, next_dir: cur_dir_in};
                  meta_re      = 1'b1;
                  meta_raddr   = addr_of(nb);
                  grid_re      = 1'b1;
                  grid_raddr   = addr_of(nb);
                  nb_in        = nb;
                  probe_dir_in = cur_dir_ff[1:0];
                  state_in     = ST_PROBE;
               end
            end
         end

         ST_PROBE: begin
            state_in = ST_STEP;
            if (!meta_q_ff.visited) begin
               meta_we    = 1'b1;
               meta_waddr = addr_of(nb_ff);
               meta_wdata = '{visited: 1'b1, from: probe_dir_ff, next_dir: 3'd0};
               if (grid_q_ff == gmds_pkg::CH_END) begin
                  cur_in   = nb_ff;
                  found_in = 1'b1;
                  state_in = ST_TRACE;
               end else if (grid_q_ff != gmds_pkg::CH_WALL) begin
                  cur_in      = nb_ff;
                  cur_dir_in  = '0;
                  cur_from_in = probe_dir_ff;
               end
            end
         end

         ST_POP_WAIT: begin
            cur_dir_in  = meta_q_ff.next_dir;
            cur_from_in = meta_q_ff.from;
            state_in    = ST_STEP;
         end

         ST_TRACE: begin
            // mark this cell, fetch its arrival direction
            grid_we    = 1'b1;
            grid_waddr = addr_of(cur_ff);
            grid_wdata = gmds_pkg::CH_MARK;
            count_in   = count_ff + LW'(1);
            if (cur_ff == start_ff) begin
               state_in = ST_DONE;
            end else begin
               meta_re    = 1'b1;
               meta_raddr = addr_of(cur_ff);
               state_in   = ST_TRACE_WAIT;
            end
         end

         ST_TRACE_WAIT: begin
            cur_in   = step_back(cur_ff, meta_q_ff.from);
            state_in = ST_TRACE;
         end

         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_len_in   = count_ff;
               rsp_cell_in  = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= gmds_pkg::GRID_ROWS_RST;
         cols_ff      <= gmds_pkg::GRID_COLS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      used_rows_ff   <= used_rows_in;
      used_cols_ff   <= used_cols_in;
      scan_ff        <= scan_in;
      scan_pend_ff   <= scan_pend_in;
      scan_prev_ff   <= scan_prev_in;
      have_start_ff  <= have_start_in;
      start_ff       <= start_in;
      cur_ff         <= cur_in;
      cur_dir_ff     <= cur_dir_in;
      cur_from_ff    <= cur_from_in;
      nb_ff          <= nb_in;
      probe_dir_ff   <= probe_dir_in;
      count_ff       <= count_in;
      found_ff       <= found_in;
      read_inside_ff <= read_inside_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_cell_ff    <= rsp_cell_in;
   end

   // Grid store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= grid_wdata;
      end
      if (grid_re) begin
         grid_q_ff <= grid_mem[grid_raddr];
      end
   end

   // Walk record store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (meta_re) begin
         meta_q_ff <= meta_mem[meta_raddr];
      end
   end

   // Checks
   a_meta_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (meta_we && meta_re) |-> (meta_waddr != meta_raddr))
      else $error("walk record read and write hit the same entry");

   a_probe_after_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE || state_ff == ST_POP_WAIT) |-> ($past(state_ff) == ST_STEP))
      else $error("probe or backtrack wait not preceded by a walk step");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (cur_dir_ff <= gmds_pkg::DIR_DONE))
      else $error("walk direction out of range");

   a_grid_write_phase: assert property (@(posedge clock) disable iff (reset)
      grid_we |-> (state_ff == ST_IDLE || state_ff == ST_TRACE))
      else $error("grid store written outside load or path marking");

   a_trace_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRACE) |-> found_ff)
      else $error("path marking without a reached end");

endmodule

[bench/grid_maze_dfs_solver_tb.sv]
// Self-checking testbench of the grid maze depth-first solver, with its own maze predictor.
`timescale 1ns / 100ps

module grid_maze_dfs_solver_tb;
   import gmds_pkg::*;

   localparam int GRID_W          = MAX_COLS_DEF;
   localparam int CELLS           = MAX_ROWS_DEF * MAX_COLS_DEF;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 40000;
   localparam int RANDOM_ITEMS    = 1600;

   // Codes the package leaves out
   localparam logic [1:0]        MODE_UNUSED = 2'd3;
   localparam logic [1:0]        CSR_SPARE_A = 2'd2;
   localparam logic [1:0]        CSR_SPARE_B = 2'd3;
   localparam logic [BYTE_W-1:0] CH_OPEN     = 8'h2E;

   // Outcome of entering a cell during the walk
   localparam int ENTER_NONE   = 0;
   localparam int ENTER_PUSHED = 1;
   localparam int ENTER_END    = 2;

   typedef struct packed {
      logic             found;
      logic [LEN_W-1:0] path_len;
      logic [BYTE_W-1:0] cell_out;
   } maze_answer_t;

   typedef struct {
      bit                  is_reg;
      logic [1:0]          code;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [BYTE_W-1:0]   val;
      bit                  typed;
      maze_answer_t        want;
   } plan_step_t;

   // DUT signals
   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // row[4:0], col[9:5], cell_byte[17:10]
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // mode[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // found[0], path_length[11:1], cell_out[19:12]
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_data   = '0;

   // Predictor state
   logic [BYTE_W-1:0] grid_mem    [CELLS];
   bit                seen_mem    [CELLS];
   logic [1:0]        arrival_mem [CELLS];
   int                dfs_cell    [CELLS];
   logic [2:0]        dfs_next    [CELLS];
   int                dfs_depth = 0;
   logic [CFG_W-1:0]  cfg_rows  = GRID_ROWS_RST;
   logic [CFG_W-1:0]  cfg_cols  = GRID_COLS_RST;

   maze_answer_t answers_due [$];
   plan_step_t   plan_q [$];
   int           mismatches   = 0;
   int           items_sent   = 0;
   int           results_seen = 0;
   bit           send_fast    = 1'b0;
   bit           rsp_fast     = 1'b0;
   bit           rsp_hold_req = 1'b0;

   grid_maze_dfs_solver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int used_dim(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (int'(v) > MAX_ROWS_DEF) return MAX_ROWS_DEF;
      return int'(v);
   endfunction

   function automatic int enter_cell(input int idx, input logic [1:0] dir);
      if (seen_mem[idx]) return ENTER_NONE;
      seen_mem[idx]    = 1'b1;
      arrival_mem[idx] = dir;
      if (grid_mem[idx] == CH_WALL) return ENTER_NONE;
      if (grid_mem[idx] == CH_END) return ENTER_END;
      if (dfs_depth < CELLS) begin
         dfs_cell[dfs_depth] = idx;
         dfs_next[dfs_depth] = {1'b0, DIR_UP};
         dfs_depth++;
      end
      return ENTER_PUSHED;
   endfunction

   // Depth-first walk from the last start, then mark the path back from the end
   function automatic void walk_maze(output maze_answer_t ans);
      int rows, cols, start, end_at, cur, here, top, nb, r, c, res, steps, count;
      bit have_start, found;
      logic [2:0] d;
      rows = used_dim(cfg_rows);
      cols = used_dim(cfg_cols);
      have_start = 1'b0;
      found = 1'b0;
      start = 0;
      end_at = 0;
      count = 0;
      for (r = 0; r < rows; r++)
         for (c = 0; c < cols; c++)
            if (grid_mem[r * GRID_W + c] == CH_START) begin
               start = r * GRID_W + c;
               have_start = 1'b1;
            end
      for (r = 0; r < CELLS; r++) seen_mem[r] = 1'b0;
      dfs_depth = 0;
      if (have_start) begin
         res = enter_cell(start, DIR_UP);
         while (dfs_depth > 0) begin
            top  = dfs_depth - 1;
            here = dfs_cell[top];
            d    = dfs_next[top];
            r    = here / GRID_W;
            c    = here % GRID_W;
            if (d >= DIR_DONE) begin
               dfs_depth--;
               continue;
            end
            dfs_next[top] = d + 3'd1;
            nb = -1;
            case (d[1:0])
               DIR_UP:   if (r != 0) nb = here - GRID_W;
               DIR_DOWN: if (r + 1 < rows) nb = here + GRID_W;
               DIR_LEFT: if (c != 0) nb = here - 1;
               default:  if (c + 1 < cols) nb = here + 1;
            endcase
            if (nb >= 0) begin
               res = enter_cell(nb, d[1:0]);
               if (res == ENTER_END) begin
                  found  = 1'b1;
                  end_at = nb;
                  break;
               end
            end
         end
      end
      dfs_depth = 0;
      if (found) begin
         cur = end_at;
         for (steps = 0; steps < CELLS; steps++) begin
            grid_mem[cur] = CH_MARK;
            count++;
            if (cur == start) break;
            case (arrival_mem[cur])
               DIR_UP:   cur += GRID_W;
               DIR_DOWN: cur -= GRID_W;
               DIR_LEFT: cur += 1;
               default:  cur -= 1;
            endcase
            if (cur < 0 || cur >= CELLS) break;
         end
      end
      ans.found    = found;
      ans.path_len = LEN_W'(count);
      ans.cell_out = '0;
   endfunction

   // Apply one item to the predicted maze; row and col always fall inside the store
   function automatic void model_maze_item(input logic [1:0] mode,
         input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
         input logic [BYTE_W-1:0] cbyte, output bit gives, output maze_answer_t ans);
      int idx;
      idx   = int'(row) * GRID_W + int'(col);
      ans   = '0;
      gives = 1'b0;
      case (mode)
         MODE_LOAD: grid_mem[idx] = cbyte;
         MODE_SOLVE: begin
            walk_maze(ans);
            gives = 1'b1;
         end
         MODE_READ: begin
            ans.cell_out = grid_mem[idx];
            gives = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int idle_gap(input bit fast);
      return fast ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [BYTE_W-1:0] open_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255));
      while (b == CH_WALL || b == CH_START || b == CH_END);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] maze_byte();
      return ($urandom_range(0, 9) < 3) ? CH_WALL : open_byte();
   endfunction

   function automatic logic [BYTE_W-1:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return CH_WALL;
         1: return CH_START;
         2: return CH_END;
         3: return CH_MARK;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly small sizes, with zero, overlarge and full-size values now and then
   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return CFG_W'($urandom_range(33, 63));
         2: return CFG_W'(MAX_ROWS_DEF);
         3: return CFG_W'(1);
         default: return CFG_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic void plan_item(input logic [1:0] mode, input int row, input int col,
         input logic [BYTE_W-1:0] val, input bit typed, input bit found, input int len,
         input logic [BYTE_W-1:0] cell_out);
      plan_step_t s;
      s.is_reg = 1'b0;
      s.code   = mode;
      s.row    = COORD_W'(row);
      s.col    = COORD_W'(col);
      s.val    = val;
      s.typed  = typed;
      s.want.found    = found;
      s.want.path_len = LEN_W'(len);
      s.want.cell_out = cell_out;
      plan_q.push_back(s);
   endfunction

   function automatic void plan_reg(input logic [1:0] idx, input int val);
      plan_step_t s;
      s.is_reg = 1'b1;
      s.code   = idx;
      s.row    = '0;
      s.col    = '0;
      s.val    = BYTE_W'(val);
      s.typed  = 1'b0;
      s.want   = '0;
      plan_q.push_back(s);
   endfunction

   task automatic report(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Offer one item after a random gap; predict once it is taken
   task automatic send_item(input logic [1:0] mode, input logic [COORD_W-1:0] row,
         input logic [COORD_W-1:0] col, input logic [BYTE_W-1:0] cbyte,
         input bit typed, input maze_answer_t typed_ans);
      int gap;
      bit gives;
      maze_answer_t ans;
      gap = idle_gap(send_fast);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'd0, cbyte, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_maze_item(mode, row, col, cbyte, gives, ans);
      if (gives) answers_due.push_back(typed ? typed_ans : ans);
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // Drain all results, then give the block time to finish a trailing load
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_GRID_ROWS) cfg_rows = val;
      else if (idx == CSR_GRID_COLS) cfg_cols = val;
   endtask

   // ---------------------------------------------------------------- result side

   task automatic check_answer(input logic [RSP_DATA_W-1:0] data);
      maze_answer_t want;
      results_seen++;
      if (answers_due.size() == 0) begin
         report($sformatf("result %0d (%h) arrived with nothing pending", results_seen, data));
         return;
      end
      want = answers_due.pop_front();
      if (data[0] !== want.found)
         report($sformatf("result %0d found %b, want %b", results_seen, data[0], want.found));
      if (data[11:1] !== want.path_len)
         report($sformatf("result %0d path_length %0d, want %0d", results_seen, data[11:1],
                          want.path_len));
      if (data[19:12] !== want.cell_out)
         report($sformatf("result %0d cell_out %h, want %h", results_seen, data[19:12],
                          want.cell_out));
   endtask

   initial begin : rsp_side
      int gap;
      while (reset) @(posedge clock);
      forever begin
         // long hold-off so the block backs up and stalls its input
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         gap = idle_gap(rsp_fast);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_answer(rsp_tdata);
         if (results_seen % 40 == 0) rsp_fast = ($urandom_range(0, 3) == 0);
      end
   end

   // End the run when no handshake happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      int r, c, er, ec, n_reads, m, stim_target;
      bit pressure_done;
      logic [CFG_W-1:0] rows_val, cols_val;
      pressure_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Load every cell once, with open bytes only, so nothing is read unwritten
      for (r = 0; r < MAX_ROWS_DEF; r++)
         for (c = 0; c < MAX_COLS_DEF; c++)
            send_item(MODE_LOAD, COORD_W'(r), COORD_W'(c), open_byte(), 1'b0, '0);

      // Directed steps
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 1, 0, 0, 8'h00);      // full size, no start
      plan_item(MODE_LOAD,  31, 31, 8'hFF, 0, 0, 0, 8'h00);
      plan_item(MODE_READ,  31, 31, 8'h00, 1, 0, 0, 8'hFF);
      plan_item(MODE_LOAD,   0,  0, 8'h00, 0, 0, 0, 8'h00);
      plan_item(MODE_READ,   0,  0, 8'hFF, 1, 0, 0, 8'h00);
      plan_item(MODE_UNUSED, 31, 31, 8'h00, 0, 0, 0, 8'h00);     // dropped, no store
      plan_item(MODE_READ,  31, 31, 8'h00, 1, 0, 0, 8'hFF);
      plan_reg(CSR_GRID_ROWS, 1);
      plan_reg(CSR_GRID_COLS, 2);
      plan_item(MODE_LOAD,   0,  0, CH_START, 0, 0, 0, 8'h00);
      plan_item(MODE_LOAD,   0,  1, CH_END,   0, 0, 0, 8'h00);
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 1, 1, 2, 8'h00);
      plan_item(MODE_READ,   0,  0, 8'h00, 1, 0, 0, CH_MARK);
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 1, 0, 0, 8'h00);      // start already used up
      plan_reg(CSR_GRID_ROWS, 0);
      plan_reg(CSR_GRID_COLS, 0);
      plan_item(MODE_LOAD,   0,  0, CH_START, 0, 0, 0, 8'h00);
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 1, 0, 0, 8'h00);      // no end reachable
      plan_item(MODE_READ,   0,  0, 8'h00, 1, 0, 0, CH_START);
      plan_reg(CSR_GRID_COLS, 3);
      plan_item(MODE_LOAD,   0,  1, CH_WALL, 0, 0, 0, 8'h00);
      plan_item(MODE_LOAD,   0,  2, CH_END,  0, 0, 0, 8'h00);
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 1, 0, 0, 8'h00);      // end behind a wall
      plan_reg(CSR_GRID_ROWS, 63);
      plan_reg(CSR_GRID_COLS, 63);
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 0, 0, 0, 8'h00);      // detour around the wall
      plan_item(MODE_READ,   0,  2, 8'h00, 1, 0, 0, CH_MARK);
      plan_reg(CSR_GRID_ROWS, 1);
      plan_reg(CSR_GRID_COLS, 4);
      plan_item(MODE_LOAD,   0,  0, CH_START, 0, 0, 0, 8'h00);   // two starts, last wins
      plan_item(MODE_LOAD,   0,  2, CH_START, 0, 0, 0, 8'h00);
      plan_item(MODE_LOAD,   0,  3, CH_END,   0, 0, 0, 8'h00);
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 1, 1, 2, 8'h00);
      plan_item(MODE_READ,   0,  0, 8'h00, 1, 0, 0, CH_START);
      plan_item(MODE_LOAD,   0,  0, CH_END,   0, 0, 0, 8'h00);   // two ends, left one first
      plan_item(MODE_LOAD,   0,  1, CH_START, 0, 0, 0, 8'h00);
      plan_item(MODE_LOAD,   0,  2, CH_END,   0, 0, 0, 8'h00);
      plan_item(MODE_SOLVE,  0,  0, 8'h00, 1, 1, 2, 8'h00);
      plan_item(MODE_READ,   0,  2, 8'h00, 1, 0, 0, CH_END);
      plan_reg(CSR_SPARE_A, 42);
      plan_reg(CSR_SPARE_B, 21);

      foreach (plan_q[i]) begin
         if (plan_q[i].is_reg)
            write_reg(plan_q[i].code, plan_q[i].val[CFG_W-1:0]);
         else
            send_item(plan_q[i].code, plan_q[i].row, plan_q[i].col, plan_q[i].val,
                      plan_q[i].typed, plan_q[i].want);
      end

      // Random phases: mostly well-formed mazes followed by a solve and reads
      stim_target = items_sent + RANDOM_ITEMS;
      while (items_sent < stim_target) begin
         rows_val = pick_dim();
         cols_val = pick_dim();
         write_reg(CSR_GRID_ROWS, rows_val);
         write_reg(CSR_GRID_COLS, cols_val);
         if ($urandom_range(0, 9) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? CSR_SPARE_A : CSR_SPARE_B, CFG_W'($urandom));
         er = used_dim(rows_val);
         ec = used_dim(cols_val);
         send_fast = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            if (er * ec <= 64) begin
               for (r = 0; r < er; r++)
                  for (c = 0; c < ec; c++)
                     send_item(MODE_LOAD, COORD_W'(r), COORD_W'(c), maze_byte(), 1'b0, '0);
            end else begin
               repeat (16)
                  send_item(MODE_LOAD, COORD_W'($urandom_range(0, er - 1)),
                            COORD_W'($urandom_range(0, ec - 1)), maze_byte(), 1'b0, '0);
            end
            repeat (($urandom_range(0, 4) == 0) ? 2 : 1)
               send_item(MODE_LOAD, COORD_W'($urandom_range(0, er - 1)),
                         COORD_W'($urandom_range(0, ec - 1)), CH_START, 1'b0, '0);
            repeat ($urandom_range(1, 2))
               send_item(MODE_LOAD, COORD_W'($urandom_range(0, er - 1)),
                         COORD_W'($urandom_range(0, ec - 1)), CH_END, 1'b0, '0);
            send_item(MODE_SOLVE, COORD_W'($urandom), COORD_W'($urandom), BYTE_W'($urandom),
                      1'b0, '0);
            if ($urandom_range(0, 3) == 0)
               send_item(MODE_SOLVE, '0, '0, '0, 1'b0, '0);
            n_reads = $urandom_range(2, 10);
            if (!pressure_done || $urandom_range(0, 9) == 0) begin
               pressure_done = 1'b1;
               rsp_hold_req  = 1'b1;
               n_reads       = 12;
            end
            repeat (n_reads) begin
               if ($urandom_range(0, 3) != 0)
                  send_item(MODE_READ, COORD_W'($urandom_range(0, er - 1)),
                            COORD_W'($urandom_range(0, ec - 1)), BYTE_W'($urandom), 1'b0, '0);
               else
                  send_item(MODE_READ, COORD_W'($urandom), COORD_W'($urandom),
                            BYTE_W'($urandom), 1'b0, '0);
            end
         end else begin
            // noise: any mode, solve only on small areas, any cell, special bytes favoured
            repeat ($urandom_range(5, 20)) begin
               m = $urandom_range(0, 3);
               if (m == MODE_SOLVE && er * ec > 64) m = MODE_READ;
               send_item(2'(m), COORD_W'($urandom), COORD_W'($urandom), noise_byte(),
                         1'b0, '0);
            end
         end
      end

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
